[rtl/core/ftcc_pkg.sv]
// Shared types, constants and the month-length table for the frame tick
// calendar clock. No dependencies.
package ftcc_pkg;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } ftcc_op_t;

    localparam logic [7:0] FPS_RESET       = 8'd60;
    localparam logic [6:0] SEC_PER_MIN     = 7'd60;
    localparam logic [6:0] MIN_PER_HOUR    = 7'd60;
    localparam logic [5:0] HOUR_PER_DAY    = 6'd24;
    localparam logic [3:0] MONTHS_PER_YEAR = 4'd12;
    localparam logic [4:0] DAY_FIRST       = 5'd1;
    localparam logic [4:0] DAY_LEN_DEFAULT = 5'd31;

    typedef struct packed {
        ftcc_op_t    op;
        logic [5:0]  load_seconds;
        logic [5:0]  load_minutes;
        logic [4:0]  load_hours;
        logic [4:0]  load_day;
        logic [3:0]  load_month;
        logic [15:0] load_year;
    } ftcc_in_t;

    typedef struct packed {
        logic [7:0]  frame_count;
        logic [15:0] total_frames;
        logic [5:0]  cur_seconds;
        logic [5:0]  cur_minutes;
        logic [4:0]  cur_hours;
        logic [4:0]  cur_day;
        logic [3:0]  cur_month;
        logic [15:0] cur_year;
    } ftcc_out_t;

    // Non-leap month lengths; months 12..15 count as 31 days.
    function automatic logic [4:0] month_len(input logic [3:0] month);
        logic [4:0] len;
        unique case (month)
            4'd1:                         len = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:      len = 5'd30;
            default:                      len = DAY_LEN_DEFAULT;
        endcase
        return len;
    endfunction

endpackage

[rtl/core/ftcc_calc.sv]
// Next-time logic: one tick or one load applied to the current time.
// Depends on ftcc_pkg.
module ftcc_calc (
    input  ftcc_pkg::ftcc_out_t cur,
    input  ftcc_pkg::ftcc_in_t  item,
    input  logic [7:0]          fps,
    output ftcc_pkg::ftcc_out_t nxt
);
    import ftcc_pkg::*;

    logic [8:0] frame_inc;
    logic [6:0] sec_inc;
    logic [6:0] min_inc;
    logic [5:0] hour_inc;
    logic [4:0] day_inc;
    logic [3:0] month_inc;
    logic       sec_step, min_step, hour_step, day_step, month_step, year_step;
    logic       sec_wrap, min_wrap, hour_wrap, day_wrap, month_wrap;

    always_comb begin
        frame_inc = {1'b0, cur.frame_count} + 9'd1;
        sec_inc   = {1'b0, cur.cur_seconds} + 7'd1;
        min_inc   = {1'b0, cur.cur_minutes} + 7'd1;
        hour_inc  = {1'b0, cur.cur_hours} + 6'd1;
        day_inc   = cur.cur_day + 5'd1;
        month_inc = cur.cur_month + 4'd1;

        // fps of zero carries on every tick
        sec_step   = (frame_inc >= {1'b0, fps});
        sec_wrap   = (sec_inc >= SEC_PER_MIN);
        min_step   = sec_step & sec_wrap;
        min_wrap   = (min_inc >= MIN_PER_HOUR);
        hour_step  = min_step & min_wrap;
        hour_wrap  = (hour_inc >= HOUR_PER_DAY);
        day_step   = hour_step & hour_wrap;
        day_wrap   = (day_inc == 5'd0) || (day_inc > month_len(cur.cur_month));
        month_step = day_step & day_wrap;
        month_wrap = (month_inc == 4'd0) || (month_inc >= MONTHS_PER_YEAR);
        year_step  = month_step & month_wrap;

        nxt = cur;
        if (item.op == OP_LOAD) begin
            nxt.cur_seconds = item.load_seconds;
            nxt.cur_minutes = item.load_minutes;
            nxt.cur_hours   = item.load_hours;
            nxt.cur_day     = item.load_day;
            nxt.cur_month   = item.load_month;
            nxt.cur_year    = item.load_year;
        end else begin
            nxt.total_frames = cur.total_frames + 16'd1;
            nxt.frame_count  = sec_step ? 8'd0 : frame_inc[7:0];
            if (sec_step) begin
                nxt.cur_seconds = sec_wrap ? 6'd0 : sec_inc[5:0];
            end
            if (min_step) begin
                nxt.cur_minutes = min_wrap ? 6'd0 : min_inc[5:0];
            end
            if (hour_step) begin
                nxt.cur_hours = hour_wrap ? 5'd0 : hour_inc[4:0];
            end
            if (day_step) begin
                nxt.cur_day = day_wrap ? DAY_FIRST : day_inc;
            end
            if (month_step) begin
                nxt.cur_month = month_wrap ? 4'd0 : month_inc;
            end
            if (year_step) begin
                nxt.cur_year = cur.cur_year + 16'd1;
            end
        end
    end

endmodule

[rtl/core/ftcc_outbuf.sv]
// Two-entry result buffer (output register plus skid register) so the
// input side keeps flowing while a result waits. Depends on ftcc_pkg.
module ftcc_outbuf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  ftcc_pkg::ftcc_out_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output ftcc_pkg::ftcc_out_t out_data
);
    import ftcc_pkg::*;

    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    ftcc_out_t out_data_reg, out_data_next;
    ftcc_out_t skid_data_reg, skid_data_next;
    logic      push, pop;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid_reg && out_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop) begin
            // skid holds the older item; push cannot happen while it is full
            out_valid_next  = skid_valid_reg || push;
            out_data_next   = skid_valid_reg ? skid_data_reg : in_data;
            skid_valid_next = 1'b0;
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_skid_drains_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && out_ready) |=> (out_valid_reg && !skid_valid_reg
            && out_data_reg == $past(skid_data_reg)))
        else $error("skid entry not moved to output on pop");

    a_stalled_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_ready) |=> (out_valid_reg
            && out_data_reg == $past(out_data_reg)))
        else $error("stalled result changed");
`endif

endmodule

[rtl/core/frame_tick_calendar_clock.sv]
// Frame tick calendar clock top level: time state, frames-per-second
// register, next-time logic and result buffer. Depends on ftcc_pkg,
// ftcc_calc and ftcc_outbuf.
//
// Each accepted item (a frame tick or a time load) updates the time state
// in the cycle it is taken and returns one result with all time fields as
// they stand after that item. One item per clock is accepted while s_ready
// is high; the result is registered in the result buffer for m_data. The
// two-entry buffer keeps s_ready high while one result waits on m_ready,
// so input stalls only after two results wait. The whole tick carry chain
// (frames, seconds, minutes, hours, day, month, year) is combinational. A
// write to frames_per_second takes effect for the next item.
module frame_tick_calendar_clock (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  ftcc_pkg::ftcc_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ftcc_pkg::ftcc_out_t m_data
);
    import ftcc_pkg::*;

    localparam ftcc_out_t TIME_RESET = '{
        frame_count:  8'd0,
        total_frames: 16'd0,
        cur_seconds:  6'd0,
        cur_minutes:  6'd0,
        cur_hours:    5'd0,
        cur_day:      DAY_FIRST,
        cur_month:    4'd0,
        cur_year:     16'd0
    };

    logic [7:0] fps_reg;
    ftcc_out_t  time_reg, time_next;
    logic       accept;

    assign accept = s_valid && s_ready;

    ftcc_calc u_calc (
        .cur  (time_reg),
        .item (s_data),
        .fps  (fps_reg),
        .nxt  (time_next)
    );

    ftcc_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (time_next),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fps_reg  <= FPS_RESET;
            time_reg <= TIME_RESET;
        end else begin
            if (cfg_wr_en) begin
                fps_reg <= cfg_wr_data;
            end
            if (accept) begin
                time_reg <= time_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_idle_holds_time: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(time_reg))
        else $error("time changed without an item");

    a_tick_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.op == OP_TICK) |=>
            (time_reg.total_frames == $past(time_reg.total_frames) + 16'd1))
        else $error("tick did not advance frame count");

    a_load_year: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.op == OP_LOAD) |=>
            (time_reg.cur_year == $past(s_data.load_year)
             && time_reg.total_frames == $past(time_reg.total_frames)))
        else $error("load item applied wrongly");

    a_result_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !m_valid) |=> (m_valid && m_data == time_reg))
        else $error("result does not match updated time");
`endif

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for frame_tick_calendar_clock: streams tick and load items,
// predicts the calendar fields and checks every result. Depends on ftcc_pkg.
module testbench;
    import ftcc_pkg::*;

    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int ITEMS_PER_PHASE = 170;
    localparam int NUM_PHASES      = 8;
    localparam int RESET_FPS       = 60;
    localparam int SECS_PER_MIN    = 60;
    localparam int MINS_PER_HOUR   = 60;
    localparam int HOURS_PER_DAY   = 24;
    localparam int MONTHS_IN_YEAR  = 12;
    localparam int OOR_MONTH_DAYS  = 31;

    logic      aclk        = 1'b0;
    logic      aresetn     = 1'b0;
    logic      cfg_wr_en   = 1'b0;
    logic [7:0] cfg_wr_data = '0;
    logic      s_valid     = 1'b0;
    ftcc_in_t  s_data      = '0;
    logic      m_ready     = 1'b0;
    logic      s_ready;
    logic      m_valid;
    ftcc_out_t m_data;

    frame_tick_calendar_clock uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    int month_days [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    int phase_rates [NUM_PHASES] = '{60, 1, 0, 255, 2, 200, 1, 59};

    // calendar prediction state
    int rate_fps;
    int cal_frames, cal_total, cal_sec, cal_min, cal_hour, cal_day, cal_month, cal_year;

    ftcc_in_t  tick_stream [$];
    ftcc_out_t pending_times [$];
    int  items_sent = 0, items_taken = 0, results_checked = 0;
    int  loads_sent = 0, rates_used = 0, mismatches = 0;
    bit  in_fire = 1'b0, out_fire = 1'b0;
    bit  idle_on = 1'b1, stall_req = 1'b0;
    int  src_gap = 0, sink_gap = 0, hold_left = 0, quiet_cycles = 0;
    ftcc_out_t want;

    function automatic ftcc_out_t advance_calendar(input ftcc_in_t item);
        ftcc_out_t r;
        int mlen;
        if (item.op == OP_LOAD) begin
            cal_sec   = item.load_seconds;
            cal_min   = item.load_minutes;
            cal_hour  = item.load_hours;
            cal_day   = item.load_day;
            cal_month = item.load_month;
            cal_year  = item.load_year;
        end else begin
            cal_total  = (cal_total + 1) & 16'hFFFF;
            cal_frames = cal_frames + 1;
            if (cal_frames >= rate_fps || cal_frames > 255) begin
                cal_frames = 0;
                cal_sec++;
                if (cal_sec >= SECS_PER_MIN) begin
                    cal_sec = 0;
                    cal_min++;
                    if (cal_min >= MINS_PER_HOUR) begin
                        cal_min = 0;
                        cal_hour++;
                        if (cal_hour >= HOURS_PER_DAY) begin
                            cal_hour = 0;
                            mlen = (cal_month < MONTHS_IN_YEAR) ? month_days[cal_month]
                                                                : OOR_MONTH_DAYS;
                            cal_day = (cal_day + 1) & 5'h1F;
                            // day past month end (or 5-bit wrap) rolls the month
                            if (cal_day == 0 || cal_day > mlen) begin
                                cal_day   = 1;
                                cal_month = (cal_month + 1) & 4'hF;
                                if (cal_month == 0 || cal_month >= MONTHS_IN_YEAR) begin
                                    cal_month = 0;
                                    cal_year  = (cal_year + 1) & 16'hFFFF;
                                end
                            end
                        end
                    end
                end
            end
        end
        r.frame_count  = cal_frames[7:0];
        r.total_frames = cal_total[15:0];
        r.cur_seconds  = cal_sec[5:0];
        r.cur_minutes  = cal_min[5:0];
        r.cur_hours    = cal_hour[4:0];
        r.cur_day      = cal_day[4:0];
        r.cur_month    = cal_month[3:0];
        r.cur_year     = cal_year[15:0];
        return r;
    endfunction

    task automatic compare_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
        end
    endtask

    function automatic ftcc_in_t random_item(input bit as_load);
        ftcc_in_t it;
        int kind, mo;
        it.op           = as_load ? OP_LOAD : OP_TICK;
        it.load_seconds = 6'($urandom_range(0, 63));
        it.load_minutes = 6'($urandom_range(0, 63));
        it.load_hours   = 5'($urandom_range(0, 31));
        it.load_day     = 5'($urandom_range(0, 31));
        it.load_month   = 4'($urandom_range(0, 15));
        it.load_year    = 16'($urandom_range(0, 65535));
        kind = $urandom_range(0, 9);
        mo   = $urandom_range(0, 11);
        if (as_load && kind >= 7) begin
            it.load_seconds = 6'($urandom_range(0, 59));
            it.load_minutes = 6'($urandom_range(0, 59));
            it.load_hours   = 5'($urandom_range(0, 23));
            it.load_month   = 4'(mo);
            it.load_day     = 5'($urandom_range(1, month_days[mo]));
        end else if (as_load && kind >= 2) begin
            // just short of a day/month/year rollover
            it.load_seconds = 6'(59 - $urandom_range(0, 5));
            it.load_minutes = 6'(59 - $urandom_range(0, 2));
            it.load_hours   = 5'(23 - $urandom_range(0, 1));
            it.load_month   = 4'(mo);
            it.load_day     = 5'(month_days[mo] - $urandom_range(0, 1));
            if ($urandom_range(0, 3) == 0)
                it.load_year = 16'hFFFF;
        end
        return it;
    endfunction

    function automatic ftcc_in_t make_load(input int s, input int mi, input int h,
                                           input int d, input int mo, input int y);
        ftcc_in_t it;
        it.op           = OP_LOAD;
        it.load_seconds = 6'(s);
        it.load_minutes = 6'(mi);
        it.load_hours   = 5'(h);
        it.load_day     = 5'(d);
        it.load_month   = 4'(mo);
        it.load_year    = 16'(y);
        return it;
    endfunction

    task automatic queue_item(input ftcc_in_t it);
        tick_stream.push_back(it);
        items_sent++;
        if (it.op == OP_LOAD)
            loads_sent++;
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (items_taken != items_sent || pending_times.size() != 0);
    endtask

    task automatic set_rate(input int fps);
        wait_drained();
        rate_fps = fps;
        rates_used++;
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= fps[7:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // input driver
    always @(negedge aclk) begin
        if (!s_valid || in_fire) begin
            if (src_gap > 0) begin
                src_gap--;
                s_valid <= 1'b0;
            end else if (tick_stream.size() == 0) begin
                s_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                src_gap = $urandom_range(1, 13) - 1;
                s_valid <= 1'b0;
            end else begin
                s_valid <= 1'b1;
                s_data  <= tick_stream.pop_front();
            end
        end
    end

    // result receiver
    always @(negedge aclk) begin
        if (stall_req) begin
            stall_req = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            sink_gap = $urandom_range(1, 13) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor and checker; results are checked before a same-edge item is predicted
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_fire  = 1'b0;
            out_fire = 1'b0;
        end else begin
            in_fire  = s_valid && s_ready;
            out_fire = m_valid && m_ready;
            if (out_fire) begin
                if (pending_times.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with nothing expected, got %p", $time, m_data);
                end else begin
                    want = pending_times.pop_front();
                    results_checked++;
                    compare_field("frame_count", want.frame_count, m_data.frame_count);
                    compare_field("total_frames", want.total_frames, m_data.total_frames);
                    compare_field("cur_seconds", want.cur_seconds, m_data.cur_seconds);
                    compare_field("cur_minutes", want.cur_minutes, m_data.cur_minutes);
                    compare_field("cur_hours", want.cur_hours, m_data.cur_hours);
                    compare_field("cur_day", want.cur_day, m_data.cur_day);
                    compare_field("cur_month", want.cur_month, m_data.cur_month);
                    compare_field("cur_year", want.cur_year, m_data.cur_year);
                end
            end
            if (in_fire) begin
                pending_times.push_back(advance_calendar(s_data));
                items_taken++;
            end
            quiet_cycles = (in_fire || out_fire) ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
                $display("frame_tick_calendar_clock verification failed");
                $finish;
            end
        end
    end

    initial begin
        int p;
        rate_fps   = RESET_FPS;
        cal_frames = 0;
        cal_total  = 0;
        cal_sec    = 0;
        cal_min    = 0;
        cal_hour   = 0;
        cal_day    = 1;
        cal_month  = 0;
        cal_year   = 0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // reset values and default rate
        repeat (3) queue_item(random_item(1'b0));
        queue_item(make_load(58, 59, 23, 31, 11, 65535));
        queue_item(random_item(1'b0));

        // one tick per second: carry chain corners
        set_rate(1);
        queue_item(make_load(59, 59, 23, 31, 11, 65535));  // year wraps
        queue_item(random_item(1'b0));
        queue_item(make_load(59, 59, 23, 28, 1, 2000));    // end of February
        queue_item(random_item(1'b0));
        queue_item(make_load(63, 63, 31, 31, 15, 100));    // all fields past range
        queue_item(random_item(1'b0));
        queue_item(make_load(59, 59, 23, 0, 5, 7));        // day zero
        queue_item(random_item(1'b0));
        queue_item(make_load(59, 59, 23, 31, 12, 5));      // month past December
        queue_item(random_item(1'b0));
        queue_item(make_load(59, 59, 23, 30, 3, 9));       // 30-day month
        queue_item(random_item(1'b0));
        queue_item(make_load(0, 0, 0, 1, 0, 0));
        queue_item(random_item(1'b0));

        // zero rate: every tick carries
        set_rate(0);
        repeat (3) queue_item(random_item(1'b0));

        for (p = 0; p < NUM_PHASES; p++) begin
            set_rate(phase_rates[p]);
            idle_on = (p != 3 && p != NUM_PHASES - 1);
            if (p == 1)
                stall_req = 1'b1;
            repeat (ITEMS_PER_PHASE) queue_item(random_item($urandom_range(0, 7) == 0));
        end

        wait_drained();
        repeat (4) @(negedge aclk);
        if (pending_times.size() != 0) begin
            mismatches++;
            $display("%0t: %0d results never arrived", $time, pending_times.size());
        end
        $display("Ran %0d items (%0d ticks, %0d time loads) over %0d frame-rate settings;",
                 items_sent, items_sent - loads_sent, loads_sent, rates_used);
        $display("%0d results checked, %0d field mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("frame_tick_calendar_clock verification clean");
        else
            $display("frame_tick_calendar_clock verification failed");
        $finish;
    end

endmodule
